### src/sglu_pkg.sv
// shared types, constants and codes of the stereo gain upsampler
`timescale 1ns / 1ps
package sglu_pkg;

  localparam int UPSAMPLE = 16;
  localparam int PH_W     = $clog2(UPSAMPLE);
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 10;
  localparam int NCHAN    = 3;

  localparam logic [GAIN_W-1:0] GAIN_MAX   = 10'd704;
  localparam logic [GAIN_W-1:0] GAIN_UNITY = 10'd256;

  // channel coefficients in hundredths: left, left, right
  localparam int COEF_W = 8;
  localparam logic [COEF_W-1:0] COEF [NCHAN] = '{8'd135, 8'd165, 8'd155};

  // scaling: |x * g * coef| / 25600, done as (>> 8) then / 100
  localparam int GC_W        = GAIN_W + COEF_W;
  localparam int PROD_W      = SAMPLE_W + GC_W + 1;
  localparam int MAG_W       = 32;
  localparam int SCALE_SHIFT = 8;
  localparam int V_W         = MAG_W - SCALE_SHIFT;
  localparam int SCALE_DIV   = 100;
  localparam logic [V_W-1:0] V_LIMIT = V_W'(SCALE_DIV * 32768);
  localparam int VLO_W       = 22;
  localparam int REC_SHIFT   = 31;
  localparam int REC_W       = 25;
  localparam logic [REC_W-1:0] REC_DIV = REC_W'((64'd1 << REC_SHIFT) / SCALE_DIV);
  localparam int QE_W        = 16;

  // interpolation accumulator and divide by the phase count
  localparam int ACC_W   = SAMPLE_W + PH_W + 1;
  localparam int DELTA_W = SAMPLE_W + 1;
  localparam int RK      = ACC_W + PH_W + 1;
  localparam int RECU_W  = RK - PH_W + 2;
  localparam logic [RECU_W-1:0] REC_UP =
    RECU_W'(((64'd1 << RK) + UPSAMPLE - 1) / UPSAMPLE);
  localparam int QPRD_W  = ACC_W + RECU_W;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_sample;
    logic signed [SAMPLE_W-1:0] right_sample;
    logic                       burst_last;
  } in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] chan_one;
    logic signed [SAMPLE_W-1:0] chan_two;
    logic signed [SAMPLE_W-1:0] chan_three;
    logic                       run_last;
    logic                       burst_end;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_GAIN,
    S_MUL,
    S_DIV,
    S_FIX,
    S_PREP,
    S_EMIT_LERP,
    S_PREP_COPY,
    S_EMIT_COPY
  } state_t;

  typedef struct packed {
    logic load;
    logic gain;
    logic mul;
    logic div;
    logic fix;
    logic hold;
    logic prep_lerp;
    logic prep_copy;
    logic emit;
    logic run_last;
    logic burst_end;
  } cmd_t;

  typedef struct packed {
    logic have_held;
    logic blast;
    logic out_free;
  } stat_t;

endpackage

### src/sglu_ctrl.sv
// sequencer of the stereo gain upsampler: scaling steps and phase runs
`timescale 1ns / 1ps
module sglu_ctrl import sglu_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  localparam logic [PH_W-1:0] PH_LAST = PH_W'(UPSAMPLE - 1);

  state_t          state_r, state_nxt;
  logic [PH_W-1:0] ph_r, ph_nxt;
  logic            ph_end;
  logic            emitting;

  assign ph_end   = (ph_r == PH_LAST);
  assign emitting = (state_r == S_EMIT_LERP || state_r == S_EMIT_COPY) && stat_i.out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ph_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ph_r    <= ph_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ph_nxt    = ph_r;
    if (emitting) begin
      ph_nxt = ph_end ? '0 : ph_r + PH_W'(1);
    end
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_GAIN;
      end
      S_GAIN: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_DIV;
      S_DIV:  state_nxt = S_FIX;
      S_FIX:  state_nxt = S_PREP;
      S_PREP: begin
        if (stat_i.have_held) state_nxt = S_EMIT_LERP;
        else if (stat_i.blast) state_nxt = S_EMIT_COPY;
        else state_nxt = S_IDLE;
      end
      S_EMIT_LERP: begin
        if (stat_i.out_free && ph_end) begin
          state_nxt = stat_i.blast ? S_PREP_COPY : S_IDLE;
        end
      end
      S_PREP_COPY: state_nxt = S_EMIT_COPY;
      S_EMIT_COPY: begin
        if (stat_i.out_free && ph_end) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o    = '0;
    in_stall = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: cmd_o.load = in_valid;
      S_GAIN: cmd_o.gain = 1'b1;
      S_MUL:  cmd_o.mul  = 1'b1;
      S_DIV:  cmd_o.div  = 1'b1;
      S_FIX:  cmd_o.fix  = 1'b1;
      S_PREP: begin
        cmd_o.hold      = 1'b1;
        cmd_o.prep_lerp = stat_i.have_held;
        cmd_o.prep_copy = !stat_i.have_held && stat_i.blast;
      end
      S_EMIT_LERP: begin
        cmd_o.emit     = stat_i.out_free;
        cmd_o.run_last = ph_end && !stat_i.blast;
      end
      S_PREP_COPY: cmd_o.prep_copy = 1'b1;
      S_EMIT_COPY: begin
        cmd_o.emit      = stat_i.out_free;
        cmd_o.run_last  = ph_end;
        cmd_o.burst_end = ph_end;
      end
      default: cmd_o = '0;
    endcase
  end

  // a result is only pushed into a free output register
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.emit |-> stat_i.out_free)
    else $error("result pushed while output register busy");

  // every run starts at phase zero
  a_idle_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_PREP || state_r == S_PREP_COPY) |-> ph_r == '0)
    else $error("phase counter not cleared between runs");

  // the copy run is the end of a burst and frees the input
  a_copy_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT_COPY && cmd_o.emit && ph_end) |=> state_r == S_IDLE)
    else $error("copy run did not end the frame");

  // a copy run always follows a burst-last frame
  a_copy_blast: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_o.prep_copy |-> stat_i.blast)
    else $error("copy run without burst-last frame");

endmodule

### src/sglu_datapath.sv
// datapath of the stereo gain upsampler: gain scaling, held frame, interpolation
`timescale 1ns / 1ps
module sglu_datapath import sglu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [GAIN_W-1:0] cfg_data,
  input  in_t               in_data,
  input  cmd_t              cmd_i,
  output stat_t             stat_o,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data
);

  localparam logic signed [ACC_W-1:0] UP_S = ACC_W'(UPSAMPLE);

  logic [GAIN_W-1:0]          gain_r;
  in_t                        in_r;
  logic [GC_W-1:0]            gc_r     [NCHAN];
  logic [GC_W-1:0]            gc_nxt   [NCHAN];
  logic                       unity_r, unity_nxt;
  logic [MAG_W-1:0]           mag_r    [NCHAN];
  logic [MAG_W-1:0]           mag_nxt  [NCHAN];
  logic                       neg_r    [NCHAN];
  logic                       neg_nxt  [NCHAN];
  logic                       big_r    [NCHAN];
  logic                       big_nxt  [NCHAN];
  logic [VLO_W-1:0]           vlo_r    [NCHAN];
  logic [VLO_W-1:0]           vlo_nxt  [NCHAN];
  logic [QE_W-1:0]            qe_r     [NCHAN];
  logic [QE_W-1:0]            qe_nxt   [NCHAN];
  logic signed [SAMPLE_W-1:0] c_r      [NCHAN];
  logic signed [SAMPLE_W-1:0] c_nxt    [NCHAN];
  logic signed [SAMPLE_W-1:0] held_r   [NCHAN];
  logic                       have_held_r;
  logic signed [ACC_W-1:0]    acc_r    [NCHAN];
  logic signed [ACC_W-1:0]    acc_nxt  [NCHAN];
  logic signed [DELTA_W-1:0]  delta_r  [NCHAN];
  logic signed [DELTA_W-1:0]  delta_nxt[NCHAN];
  logic signed [SAMPLE_W-1:0] lerp_val [NCHAN];
  out_t                       out_r, out_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [GAIN_W-1:0]          g_clip;
  logic signed [SAMPLE_W-1:0] x        [NCHAN];

  assign g_clip = (gain_r > GAIN_MAX) ? GAIN_MAX : gain_r;
  assign x[0]   = in_r.left_sample;
  assign x[1]   = in_r.left_sample;
  assign x[2]   = in_r.right_sample;

  // gain times coefficient, then sample times that
  always_comb begin
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] pabs;
    unity_nxt = (g_clip == GAIN_UNITY);
    for (int i = 0; i < NCHAN; i++) begin
      gc_nxt[i]  = GC_W'(g_clip) * GC_W'(COEF[i]);
      prod       = $signed({{(PROD_W-SAMPLE_W){x[i][SAMPLE_W-1]}}, x[i]}) *
                   $signed({{(PROD_W-GC_W){1'b0}}, gc_r[i]});
      pabs       = prod[PROD_W-1] ? -prod : prod;
      mag_nxt[i] = pabs[MAG_W-1:0];
      neg_nxt[i] = prod[PROD_W-1];
    end
  end

  // divide by 100 through the reciprocal, estimate may be one low
  always_comb begin
    logic [V_W-1:0]         v;
    logic [VLO_W+REC_W-1:0] qprod;
    for (int i = 0; i < NCHAN; i++) begin
      v          = mag_r[i][MAG_W-1:SCALE_SHIFT];
      big_nxt[i] = (v >= V_LIMIT);
      vlo_nxt[i] = v[VLO_W-1:0];
      qprod      = {{REC_W{1'b0}}, v[VLO_W-1:0]} * {{VLO_W{1'b0}}, REC_DIV};
      qe_nxt[i]  = qprod[REC_SHIFT +: QE_W];
    end
  end

  // correction, sign, saturation, or the sample itself at unity gain
  always_comb begin
    logic [VLO_W-1:0]    qm;
    logic [VLO_W-1:0]    rem;
    logic [SAMPLE_W:0]   q;
    logic [SAMPLE_W:0]   qneg;
    for (int i = 0; i < NCHAN; i++) begin
      qm   = VLO_W'(qe_r[i]) * VLO_W'(SCALE_DIV);
      rem  = vlo_r[i] - qm;
      q    = {1'b0, qe_r[i]} + ((rem >= VLO_W'(SCALE_DIV)) ? (SAMPLE_W+1)'(1) : '0);
      if (big_r[i]) q = (SAMPLE_W+1)'(32768);
      qneg = -q;
      if (unity_r) c_nxt[i] = x[i];
      else if (neg_r[i]) c_nxt[i] = qneg[SAMPLE_W-1:0];
      else if (q[SAMPLE_W] || q[SAMPLE_W-1]) c_nxt[i] = 16'sh7fff;
      else c_nxt[i] = q[SAMPLE_W-1:0];
    end
  end

  // run setup: accumulator starts at UPSAMPLE * start value, then steps by delta
  always_comb begin
    logic signed [ACC_W-1:0]   hext;
    logic signed [ACC_W-1:0]   cext;
    logic signed [DELTA_W-1:0] h17;
    logic signed [DELTA_W-1:0] c17;
    for (int i = 0; i < NCHAN; i++) begin
      hext = {{(ACC_W-SAMPLE_W){held_r[i][SAMPLE_W-1]}}, held_r[i]};
      cext = {{(ACC_W-SAMPLE_W){c_r[i][SAMPLE_W-1]}}, c_r[i]};
      h17  = {held_r[i][SAMPLE_W-1], held_r[i]};
      c17  = {c_r[i][SAMPLE_W-1], c_r[i]};
      if (cmd_i.prep_lerp) begin
        acc_nxt[i]   = hext * UP_S;
        delta_nxt[i] = c17 - h17;
      end else if (cmd_i.prep_copy) begin
        acc_nxt[i]   = cext * UP_S;
        delta_nxt[i] = '0;
      end else begin
        acc_nxt[i]   = acc_r[i] + {{(ACC_W-DELTA_W){delta_r[i][DELTA_W-1]}}, delta_r[i]};
        delta_nxt[i] = delta_r[i];
      end
    end
  end

  // accumulator / UPSAMPLE, truncated toward zero
  always_comb begin
    logic [ACC_W-1:0]    amag;
    logic [QPRD_W-1:0]   qp;
    logic [SAMPLE_W:0]   qu;
    logic [SAMPLE_W:0]   qn;
    for (int i = 0; i < NCHAN; i++) begin
      amag = acc_r[i][ACC_W-1] ? ACC_W'(-acc_r[i]) : ACC_W'(acc_r[i]);
      qp   = {{RECU_W{1'b0}}, amag} * {{ACC_W{1'b0}}, REC_UP};
      qu   = qp[RK +: SAMPLE_W+1];
      qn   = -qu;
      lerp_val[i] = acc_r[i][ACC_W-1] ? qn[SAMPLE_W-1:0] : qu[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd_i.emit) begin
      out_nxt.chan_one   = lerp_val[0];
      out_nxt.chan_two   = lerp_val[1];
      out_nxt.chan_three = lerp_val[2];
      out_nxt.run_last   = cmd_i.run_last;
      out_nxt.burst_end  = cmd_i.burst_end;
      out_valid_nxt      = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= GAIN_UNITY;
      have_held_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NCHAN; i++) held_r[i] <= '0;
    end else begin
      if (cfg_we) gain_r <= cfg_data;
      out_valid_r <= out_valid_nxt;
      if (cmd_i.hold) begin
        have_held_r <= !in_r.burst_last;
        for (int i = 0; i < NCHAN; i++) begin
          held_r[i] <= in_r.burst_last ? '0 : c_r[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load) in_r <= in_data;
    if (cmd_i.gain) unity_r <= unity_nxt;
    out_r <= out_nxt;
    for (int i = 0; i < NCHAN; i++) begin
      if (cmd_i.gain) gc_r[i] <= gc_nxt[i];
      if (cmd_i.mul) begin
        mag_r[i] <= mag_nxt[i];
        neg_r[i] <= neg_nxt[i];
      end
      if (cmd_i.div) begin
        big_r[i] <= big_nxt[i];
        vlo_r[i] <= vlo_nxt[i];
        qe_r[i]  <= qe_nxt[i];
      end
      if (cmd_i.fix) c_r[i] <= c_nxt[i];
      if (cmd_i.prep_lerp || cmd_i.prep_copy || cmd_i.emit) begin
        acc_r[i]   <= acc_nxt[i];
        delta_r[i] <= delta_nxt[i];
      end
    end
  end

  assign stat_o.have_held = have_held_r;
  assign stat_o.blast     = in_r.burst_last;
  assign stat_o.out_free  = !out_valid_r || !out_stall;
  assign out_valid        = out_valid_r;
  assign out_data         = out_r;

endmodule

### src/stereo_gain_linear_upsampler_top.sv
// top level of the stereo gain linear upsampler
//
// input channel: in_valid / in_stall carry one stereo frame request (in_data).
// a frame is taken when in_valid is high and in_stall is low. the block works
// on one frame at a time; in_stall is high from the cycle after acceptance
// until its last result sits in the output register, or its setup ends if none.
// result channel: out_valid / out_stall, 0, 1 or 2 runs of UPSAMPLE 3-channel results per frame.
// config: cfg_valid / cfg_ready write gain_q8 (cfg_data); cfg_ready is always
// high, write only while no frame is in flight.
// sequence: after acceptance the frame passes gain, multiply, reciprocal divide,
// correction and run setup; the results of each run then leave through the
// output register, and a new result may enter as the receiver takes the previous
// one. a frame with both runs has a copy setup step between the interpolation run
// and the copy run; a frame with no held frame and no burst end makes no results.
// a stalled receiver freezes the phase counter and the output register.
// reset (rst_n low, synchronous) drops any held frame and sets gain to 1.0.
`timescale 1ns / 1ps
module stereo_gain_linear_upsampler_top import sglu_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [GAIN_W-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  sglu_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat_i   (stat),
    .cmd_o    (cmd)
  );

  sglu_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd_i     (cmd),
    .stat_o    (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### tb/tb_stereo_gain_linear_upsampler_top.sv
// testbench of the stereo gain linear upsampler: random bursts checked by a scoreboard
`timescale 1ns / 1ps
module tb_stereo_gain_linear_upsampler_top import sglu_pkg::*; ();

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 12;
  localparam int TAIL        = 40;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 40;
  localparam longint GAIN_DIV = 25600;
  localparam logic signed [SAMPLE_W-1:0] SMAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SMIN = 16'sh8000;

  class upsample_scoreboard;
    out_t expected_frames[$];
    logic [GAIN_W-1:0] gain;
    logic signed [SAMPLE_W-1:0] held[NCHAN];
    bit have_held;
    int errors;
    int frames_seen;
    int results_seen;
    int bursts_closed;

    function new();
      gain = GAIN_UNITY;
      held = '{0, 0, 0};
      have_held = 0;
      errors = 0;
      frames_seen = 0;
      results_seen = 0;
      bursts_closed = 0;
    endfunction

    function void set_gain(logic [GAIN_W-1:0] g);
      gain = g;
    endfunction

    function logic signed [SAMPLE_W-1:0] clip(longint v);
      if (v > longint'(SMAX)) return SMAX;
      if (v < longint'(SMIN)) return SMIN;
      return v[SAMPLE_W-1:0];
    endfunction

    // x * gain * coef / 25600, truncated toward zero
    function logic signed [SAMPLE_W-1:0] scale_channel(logic signed [SAMPLE_W-1:0] x,
                                                       longint g, int ch);
      longint prod;
      prod = longint'(x) * g * longint'(COEF[ch]);
      return clip(prod / GAIN_DIV);
    endfunction

    function logic signed [SAMPLE_W-1:0] interp_phase(logic signed [SAMPLE_W-1:0] a,
                                                      logic signed [SAMPLE_W-1:0] b,
                                                      int p);
      longint acc;
      acc = longint'(UPSAMPLE - p) * longint'(a) + longint'(p) * longint'(b);
      return clip(acc / UPSAMPLE);
    endfunction

    function void note_frame(in_t f);
      logic signed [SAMPLE_W-1:0] cur[NCHAN];
      out_t r;
      longint g;
      g = (gain > GAIN_MAX) ? longint'(GAIN_MAX) : longint'(gain);
      frames_seen++;
      if (g == longint'(GAIN_UNITY)) begin
        cur = '{f.left_sample, f.left_sample, f.right_sample};
      end else begin
        cur[0] = scale_channel(f.left_sample, g, 0);
        cur[1] = scale_channel(f.left_sample, g, 1);
        cur[2] = scale_channel(f.right_sample, g, 2);
      end
      if (have_held) begin
        for (int p = 0; p < UPSAMPLE; p++) begin
          r.chan_one   = interp_phase(held[0], cur[0], p);
          r.chan_two   = interp_phase(held[1], cur[1], p);
          r.chan_three = interp_phase(held[2], cur[2], p);
          r.run_last   = !f.burst_last && (p == UPSAMPLE - 1);
          r.burst_end  = 1'b0;
          expected_frames.push_back(r);
        end
      end
      if (f.burst_last) begin
        // burst end: hold the scaled frame for a full run, then drop it
        for (int p = 0; p < UPSAMPLE; p++) begin
          r.chan_one   = cur[0];
          r.chan_two   = cur[1];
          r.chan_three = cur[2];
          r.run_last   = (p == UPSAMPLE - 1);
          r.burst_end  = (p == UPSAMPLE - 1);
          expected_frames.push_back(r);
        end
        held = '{0, 0, 0};
        have_held = 0;
        bursts_closed++;
      end else begin
        held = cur;
        have_held = 1;
      end
    endfunction

    task report(string msg);
      $display("ERROR at %0t ns: %s", $time, msg);
      errors++;
    endtask

    task check_result(out_t got);
      out_t want;
      if (expected_frames.size() == 0) begin
        report($sformatf("result %0d arrived with none outstanding", results_seen));
        results_seen++;
        return;
      end
      want = expected_frames.pop_front();
      if (got.chan_one !== want.chan_one)
        report($sformatf("result %0d chan_one %0d, want %0d",
                         results_seen, got.chan_one, want.chan_one));
      if (got.chan_two !== want.chan_two)
        report($sformatf("result %0d chan_two %0d, want %0d",
                         results_seen, got.chan_two, want.chan_two));
      if (got.chan_three !== want.chan_three)
        report($sformatf("result %0d chan_three %0d, want %0d",
                         results_seen, got.chan_three, want.chan_three));
      if (got.run_last !== want.run_last)
        report($sformatf("result %0d run_last %b, want %b",
                         results_seen, got.run_last, want.run_last));
      if (got.burst_end !== want.burst_end)
        report($sformatf("result %0d burst_end %b, want %b",
                         results_seen, got.burst_end, want.burst_end));
      results_seen++;
    endtask
  endclass

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_t               in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_t              out_data;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [GAIN_W-1:0] cfg_data  = '0;

  upsample_scoreboard sb = new();
  bit tx_quiet = 0;
  bit rx_quiet = 0;
  int cycle_count = 0;
  int gain_writes = 0;

  stereo_gain_linear_upsampler_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, sb.expected_frames.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) sb.check_result(out_data);
  end

  // receiver: random stall before each result, none while rx_quiet is set
  initial begin
    int n;
    forever begin
      n = rx_quiet ? 0 : $urandom_range(0, 9);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
    end
  end

  function automatic in_t make_frame(logic signed [SAMPLE_W-1:0] l,
                                     logic signed [SAMPLE_W-1:0] r, logic last);
    in_t f;
    f.left_sample  = l;
    f.right_sample = r;
    f.burst_last   = last;
    return f;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return SMAX;
      1: return SMIN;
      2: return SAMPLE_W'(int'($urandom_range(0, 64)) - 32);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic send_frame(input in_t f);
    int gap;
    gap = tx_quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= f;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_frame(f);
  endtask

  // sample the queue away from the edge so the monitor has already popped
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_frames.size() != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_gain(input logic [GAIN_W-1:0] g);
    wait_drained();
    // a burst-opening request makes no results but may still be in flight
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= g;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    sb.set_gain(g);
    gain_writes++;
  endtask

  initial begin
    logic [GAIN_W-1:0] g;
    int left;
    logic last;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // unit gain after reset: pass-through, single-frame burst and a short burst
    send_frame(make_frame(SMAX, SMIN, 1'b1));
    send_frame(make_frame(SMIN, SMAX, 1'b0));
    send_frame(make_frame(SMAX, SMIN, 1'b0));
    send_frame(make_frame(16'sd0, 16'sd0, 1'b0));
    send_frame(make_frame(-16'sd1, 16'sd1, 1'b1));
    // largest gain: clamping on both rails
    write_gain(GAIN_MAX);
    send_frame(make_frame(SMAX, SMIN, 1'b0));
    send_frame(make_frame(SMIN, SMAX, 1'b0));
    send_frame(make_frame(16'sd100, -16'sd100, 1'b1));
    // zero gain
    write_gain('0);
    send_frame(make_frame(16'sd1234, -16'sd1234, 1'b0));
    send_frame(make_frame(SMAX, SMIN, 1'b1));
    // gain above range saturates
    write_gain('1);
    send_frame(make_frame(16'sd20000, -16'sd20000, 1'b1));
    // just below unity goes through the scaler
    write_gain(GAIN_UNITY - GAIN_W'(1));
    send_frame(make_frame(SMAX, SMIN, 1'b0));
    send_frame(make_frame(-16'sd7, 16'sd7, 1'b1));

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: g = GAIN_UNITY;
        1: g = GAIN_MAX + GAIN_W'(1);
        2: g = GAIN_UNITY + GAIN_W'(1);
        default: g = GAIN_W'($urandom_range(0, (1 << GAIN_W) - 1));
      endcase
      write_gain(g);
      tx_quiet = (ph == 3);
      rx_quiet = (ph == 3 || ph == 6);
      left = 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (left == 0) left = $urandom_range(1, 8);
        left--;
        if (ph == 2 && i == PHASE_ITEMS / 2) wait_drained();
        // occasional early burst end
        last = (left == 0) || ($urandom_range(0, 19) == 0);
        if (last) left = 0;
        send_frame(make_frame(rand_sample(), rand_sample(), last));
      end
    end

    wait_drained();
    repeat (TAIL) @(posedge clk);
    $display("covered %0d frames in %0d closed bursts over %0d gain writes",
             sb.frames_seen, sb.bursts_closed, gain_writes);
    $display("%0d results checked, %0d errors", sb.results_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
src/sglu_pkg.sv
src/sglu_ctrl.sv
src/sglu_datapath.sv
src/stereo_gain_linear_upsampler_top.sv
tb/tb_stereo_gain_linear_upsampler_top.sv
